// ----- hw/rtl/lef_pkg.sv -----
`default_nettype none

package lef_pkg;

   localparam int PIXEL_W     = 8;
   localparam int ROW_W       = 12;
   localparam int OUT_COL_W   = 9;
   localparam int FW_W        = 10;
   localparam int FH_W        = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int RSP_SLOTS   = 3;
   localparam int LEVEL_W     = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 10'd416;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd240;
   localparam logic [FH_W-1:0] MAX_HEIGHT         = 13'd4096;

   // one line buffer entry: the two most recent rows of a column
   typedef struct packed {
      logic [PIXEL_W-1:0] older;
      logic [PIXEL_W-1:0] prev;
   } line_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   edge_value;
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 frame_last;
   } rsp_type;

   // 4*centre - up - down - left - right, modulo 256
   function automatic logic [PIXEL_W-1:0] lap(
      input logic [PIXEL_W-1:0] centre,
      input logic [PIXEL_W-1:0] up,
      input logic [PIXEL_W-1:0] down,
      input logic [PIXEL_W-1:0] left,
      input logic [PIXEL_W-1:0] right
   );
      logic [PIXEL_W-1:0] centre4;
      centre4 = {centre[PIXEL_W-3:0], 2'b00};
      return centre4 - up - down - left - right;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lef_line_mem.sv -----
`default_nettype none

module lef_line_mem
   import lef_pkg::*;
#(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire line_word_type     wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output line_word_type          rd_data
);

   line_word_type mem_ff [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // same-entry write forwards to the read port
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lef_rsp_queue.sv -----
`default_nettype none

module lef_rsp_queue
   import lef_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [LEVEL_W-1:0] push_n,
   input  wire rsp_type            push_data [RSP_SLOTS],
   input  wire logic               pop,
   output logic [LEVEL_W-1:0]      level,
   output rsp_type                 head
);

   rsp_type            slot_ff [RSP_SLOTS];
   rsp_type            slot_in [RSP_SLOTS];
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [LEVEL_W-1:0] base;
   logic [LEVEL_W-1:0] idx;

   always_comb begin
      base     = level_ff - LEVEL_W'(pop);
      level_in = base + push_n;
      idx      = '0;
      for (int i = 0; i < RSP_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
         idx        = LEVEL_W'(i) - base;
         if (LEVEL_W'(i) < base) begin
            if (pop) begin
               slot_in[i] = slot_ff[(i + 1) % RSP_SLOTS];
            end
         end else if (idx < push_n) begin
            slot_in[i] = push_data[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign level = level_ff;
   assign head  = slot_ff[0];

endmodule

`default_nettype wire

// ----- hw/rtl/laplacian_edge_filter.sv -----
`default_nettype none

// Streaming 4-neighbour Laplacian (4*centre minus up, down, left and right, modulo 256) on
// 8-bit luma in raster order, with neighbours outside the frame taken as zero. Two rows are
// kept in one line memory of MAX_WIDTH entries with one read and one write port; each pixel
// reads the entry one column ahead and writes its own column back, so on rows 0 to
// frame_height-2 one pixel is taken every clock unless the result queue is full, and the
// result for the pixel above goes through that queue to rsp_. Row 0 gives no result unless
// it is also the last row. On a last row below row 0 every pixel after the first yields
// two results and the single result port sets the pace; the final pixel of the frame
// yields up to three results, flagged by rsp_frame_last on the last, and waits until the
// three-entry result queue has room for all of them. req_stall and csr_ready hold off
// during reset. A write of frame_width or frame_height goes through csr_; the user must
// make it only while the block holds no undelivered transaction; it is not enforced.
module laplacian_edge_filter
   import lef_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PIXEL_W-1:0]     req_pixel,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [PIXEL_W-1:0]          rsp_edge_value,
   output logic [ROW_W-1:0]            rsp_out_row,
   output logic [OUT_COL_W-1:0]        rsp_out_col,
   output logic                        rsp_frame_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCNT_W = COL_W + 1;
   localparam int CMP_W  = (WCNT_W > FW_W) ? WCNT_W : FW_W;

   logic [FW_W-1:0]  frame_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic [ROW_W-1:0] row_count_ff;
   logic [ROW_W-1:0] row_count_in;
   logic [COL_W-1:0] col_count_ff;
   logic [COL_W-1:0] col_count_in;

   line_word_type      cur_ff;
   line_word_type      cur_in;
   line_word_type      col0_ff;
   logic [PIXEL_W-1:0] lcen_ff;
   logic [PIXEL_W-1:0] lpx_ff;
   logic [PIXEL_W-1:0] lpx2_ff;

   logic [CMP_W-1:0]  fw_ext;
   logic [WCNT_W-1:0] w_eff;
   logic [FH_W-1:0]   h_eff;
   logic              restart;
   logic [ROW_W-1:0]  r;
   logic [COL_W-1:0]  c;
   logic [COL_W-1:0]  c_prev;
   logic [WCNT_W-1:0] c_plus1;
   logic              last_col;
   logic              last_row;
   logic              has_up;
   logic              has_up2;
   logic              has_left;
   logic              has_left2;
   logic [31:0]       col32;
   logic [31:0]       col_prev32;

   logic [COL_W-1:0]  base_col;
   logic [WCNT_W-1:0] rd_next;
   logic [COL_W-1:0]  rd_addr;
   line_word_type     rd_data;
   line_word_type     wr_data;

   rsp_type            res_main;
   rsp_type            res_left;
   rsp_type            res_final;
   logic               v_main;
   logic               v_left;
   logic               v_final;
   rsp_type            push_data [RSP_SLOTS];
   logic [LEVEL_W-1:0] push_n;
   logic [LEVEL_W-1:0] level;
   rsp_type            head;
   logic               accept;
   logic               pop;

   // effective frame size
   always_comb begin
      fw_ext = CMP_W'(frame_width_ff);
      if (fw_ext == '0) begin
         w_eff = WCNT_W'(1);
      end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = WCNT_W'(MAX_WIDTH);
      end else begin
         w_eff = WCNT_W'(fw_ext);
      end
      if (frame_height_ff == '0) begin
         h_eff = FH_W'(1);
      end else if (frame_height_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // position of the incoming pixel
   always_comb begin
      restart   = ({1'b0, row_count_ff} >= h_eff) || ({1'b0, col_count_ff} >= w_eff);
      r         = restart ? '0 : row_count_ff;
      c         = restart ? '0 : col_count_ff;
      c_prev    = c - COL_W'(1);
      c_plus1   = {1'b0, c} + WCNT_W'(1);
      last_col  = (c_plus1 == w_eff);
      last_row  = ({1'b0, r} == FH_W'(h_eff - FH_W'(1)));
      has_up    = (r != '0);
      has_up2   = (r[ROW_W-1:1] != '0);
      has_left  = (c != '0);
      has_left2 = (c[COL_W-1:1] != '0);
      col32      = 32'(c);
      col_prev32 = 32'(c_prev);
   end

   // candidate results of this pixel
   always_comb begin
      res_main.edge_value = lap(cur_ff.prev,
                                has_up2  ? cur_ff.older  : '0,
                                req_pixel,
                                has_left ? lcen_ff       : '0,
                                last_col ? '0            : rd_data.prev);
      res_main.out_row    = r - ROW_W'(1);
      res_main.out_col    = col32[OUT_COL_W-1:0];
      res_main.frame_last = 1'b0;

      res_left.edge_value = lap(lpx_ff,
                                has_up    ? lcen_ff : '0,
                                '0,
                                has_left2 ? lpx2_ff : '0,
                                req_pixel);
      res_left.out_row    = r;
      res_left.out_col    = col_prev32[OUT_COL_W-1:0];
      res_left.frame_last = 1'b0;

      res_final.edge_value = lap(req_pixel,
                                 has_up   ? cur_ff.prev : '0,
                                 '0,
                                 has_left ? lpx_ff      : '0,
                                 '0);
      res_final.out_row    = r;
      res_final.out_col    = col32[OUT_COL_W-1:0];
      res_final.frame_last = 1'b1;

      v_main  = has_up;
      v_left  = last_row && has_left;
      v_final = last_row && last_col;

      push_data[0] = v_main ? res_main : (v_left ? res_left : res_final);
      push_data[1] = (v_main && v_left) ? res_left : res_final;
      push_data[2] = res_final;
      push_n       = LEVEL_W'(v_main) + LEVEL_W'(v_left) + LEVEL_W'(v_final);
   end

   assign req_stall = reset || (({1'b0, level} + {1'b0, push_n}) > 3'(RSP_SLOTS));
   assign accept    = req_valid && !req_stall;

   // counters, line window and read-ahead address
   always_comb begin
      if (last_col) begin
         col_count_in = '0;
         row_count_in = last_row ? '0 : (r + ROW_W'(1));
      end else begin
         col_count_in = c_plus1[COL_W-1:0];
         row_count_in = r;
      end
      wr_data.older = cur_ff.prev;
      wr_data.prev  = req_pixel;
      if (last_col) begin
         cur_in = has_left ? col0_ff : wr_data;
      end else begin
         cur_in = rd_data;
      end
      base_col = accept ? col_count_in : col_count_ff;
      rd_next  = {1'b0, base_col} + WCNT_W'(1);
      rd_addr  = (rd_next >= WCNT_W'(MAX_WIDTH)) ? '0 : rd_next[COL_W-1:0];
   end

   lef_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (c),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (accept) begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff  <= cur_in;
         lcen_ff <= cur_ff.prev;
         lpx2_ff <= lpx_ff;
         lpx_ff  <= req_pixel;
         if (!has_left) begin
            col0_ff <= wr_data;
         end
      end
   end

   // configuration registers
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[FW_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[FH_W-1:0];
            end
         endcase
      end
   end

   // result queue
   assign pop = rsp_valid && !rsp_stall;

   lef_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (accept ? push_n : '0),
      .push_data (push_data),
      .pop       (pop),
      .level     (level),
      .head      (head)
   );

   assign rsp_valid      = (level != '0);
   assign rsp_edge_value = head.edge_value;
   assign rsp_out_row    = head.out_row;
   assign rsp_out_col    = head.out_col;
   assign rsp_frame_last = head.frame_last;

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      accept && (push_n != '0) |=> rsp_valid)
      else $error("accepted transaction with results left the result port empty");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && v_final |=> (row_count_ff == '0) && (col_count_ff == '0))
      else $error("counters did not return to the frame origin after the final pixel");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_count_ff} < WCNT_W'(MAX_WIDTH))
      else $error("column counter beyond line memory depth");

endmodule

`default_nettype wire
